// ===== hdl/fa_pkg.sv =====
// ----------------------------------------------------------------------------
// fa_pkg
// shared types, operation codes and command structs for the fraction alu
// ----------------------------------------------------------------------------
package fa_pkg;

  localparam int OPW = 32;
  localparam int MW  = 2 * OPW;
  localparam int CW  = $clog2(OPW + 2);

  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_DIV = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_SUB = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture operands
    logic mul0;       // first cross products
    logic mul1;       // second cross products and arithmetic result
    logic gcd_init;   // set up gcd from magnitudes
    logic gcd_step;   // one subtract-and-shift gcd step
    logic div_init;   // set up divisions by the gcd
    logic div_step;   // one restoring division bit
    logic red_done;   // form reduce result
    logic zero_res;   // result 0/0
  } fa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       red_zero;  // a zero part in reduce
    logic       gcd_done;
    logic       div_done;
  } fa_sts_t;

endpackage

// ===== hdl/fa_datapath.sv =====
// ----------------------------------------------------------------------------
// fa_datapath
// operand registers, multiplier, binary gcd and serial divider
// ----------------------------------------------------------------------------
module fa_datapath
  import fa_pkg::*;
(
  input  logic                  clk,
  input  fa_cmd_t               cmd,
  output fa_sts_t               sts,
  input  logic [2:0]            in_op,
  input  logic [OPW-1:0]        in_an,
  input  logic [OPW-1:0]        in_ad,
  input  logic [OPW-1:0]        in_bn,
  input  logic [OPW-1:0]        in_bd,
  output logic [MW-1:0]         res_num,
  output logic [MW-1:0]         res_den,
  output logic                  res_ovf
);

  logic [2:0]            op;
  logic signed [OPW-1:0] an, ad, bn, bd;
  logic signed [MW-1:0]  p0;
  logic [OPW:0]          gx, gy;     // gcd working values
  logic [CW-1:0]         gk;         // common power of two
  logic [OPW-1:0]        qn, qd, rn, rd, dv;
  logic [CW-1:0]         dcnt;
  logic                  neg;

  // multiplier operand selection
  logic signed [OPW-1:0] ma, mb;
  logic signed [MW-1:0]  prod;
  always_comb begin
    ma = an;
    mb = bn;
    if (cmd.mul0) begin
      ma = an;
      mb = (op == OP_MUL) ? bn : bd;
    end else begin
      ma = ad;
      mb = (op == OP_MUL) ? bd : ((op == OP_DIV) ? bn : bd);
    end
  end
  assign prod = ma * mb;

  // cross term b_num*a_den for add and subtract
  logic signed [MW-1:0] cross_p;
  assign cross_p = bn * ad;

  logic [OPW-1:0] man, mad;
  assign man = an[OPW-1] ? OPW'(-an) : OPW'(an);
  assign mad = ad[OPW-1] ? OPW'(-ad) : OPW'(ad);

  // gcd step: remove twos, subtract smaller from larger
  logic [OPW:0] dxy, dyx;
  assign dxy = gx - gy;
  assign dyx = gy - gx;

  // divider trial subtraction
  logic [OPW:0] tn, td;
  assign tn = {rn, qn[OPW-1]} - {1'b0, dv};
  assign td = {rd, qd[OPW-1]} - {1'b0, dv};

  // wrapping sum or difference of the cross products
  logic [MW-1:0] sum;
  assign sum = (op == OP_SUB) ? MW'(p0 - cross_p) : MW'(p0 + cross_p);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      an <= in_an;
      ad <= in_ad;
      bn <= in_bn;
      bd <= in_bd;
    end
    if (cmd.mul0) p0 <= prod;
    if (cmd.mul1) begin
      res_ovf <= 1'b0;
      res_den <= MW'(prod);
      case (op)
        OP_MUL, OP_DIV: res_num <= MW'(p0);
        OP_ADD: begin
          res_num <= sum;
          res_ovf <= (p0[MW-1] == cross_p[MW-1]) && (sum[MW-1] != p0[MW-1]);
        end
        OP_SUB: begin
          res_num <= sum;
          res_ovf <= (p0[MW-1] != cross_p[MW-1]) && (sum[MW-1] != p0[MW-1]);
        end
        default: begin
          res_num <= '0;
          res_den <= '0;
        end
      endcase
    end
    if (cmd.gcd_init) begin
      gx  <= {1'b0, man};
      gy  <= {1'b0, mad};
      gk  <= '0;
      neg <= an[OPW-1] ^ ad[OPW-1];
    end else if (cmd.gcd_step) begin
      if (sts.gcd_done) begin
        // one value is zero; keep the odd part in gy for the divisor
        gy <= gx | gy;
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 1'b1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= dxy >> 1;
      end else begin
        gy <= dyx >> 1;
      end
    end
    if (cmd.div_init) begin
      dv   <= OPW'(gy << gk);
      qn   <= man;
      qd   <= mad;
      rn   <= '0;
      rd   <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (!tn[OPW]) begin
        rn <= tn[OPW-1:0];
        qn <= {qn[OPW-2:0], 1'b1};
      end else begin
        rn <= {rn[OPW-2:0], qn[OPW-1]};
        qn <= {qn[OPW-2:0], 1'b0};
      end
      if (!td[OPW]) begin
        rd <= td[OPW-1:0];
        qd <= {qd[OPW-2:0], 1'b1};
      end else begin
        rd <= {rd[OPW-2:0], qd[OPW-1]};
        qd <= {qd[OPW-2:0], 1'b0};
      end
    end
    if (cmd.red_done) begin
      res_num <= neg ? -MW'(qn) : MW'(qn);
      res_den <= MW'(qd);
      res_ovf <= 1'b0;
    end
    if (cmd.zero_res) begin
      res_num <= '0;
      res_den <= '0;
      res_ovf <= 1'b0;
    end
  end

  // gcd finishes when one value reaches zero; the other is the odd part
  assign sts.op       = op;
  assign sts.red_zero = (an == '0) || (ad == '0);
  assign sts.gcd_done = (gx == '0) || (gy == '0);
  assign sts.div_done = (dcnt == CW'(OPW));

endmodule

// ===== hdl/fa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fa_ctrl
// sequencer for arithmetic and reduce operations, output handshake
// ----------------------------------------------------------------------------
module fa_ctrl
  import fa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  output logic    in_rdy,
  output logic    out_vld,
  input  logic    out_rdy,
  output fa_cmd_t cmd,
  input  fa_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_GFIX = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;

  assign in_rdy  = (state == S_IDLE);
  assign out_vld = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_next = S_MUL0;
      end
      S_MUL0: begin
        if (sts.op == OP_RED) begin
          if (sts.red_zero) begin
            cmd.zero_res = 1'b1;
            state_next   = S_OUT;
          end else begin
            cmd.gcd_init = 1'b1;
            state_next   = S_GCD;
          end
        end else begin
          cmd.mul0   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_OUT;
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (sts.gcd_done) state_next = S_GFIX;
      end
      S_GFIX: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.red_done = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_rdy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_rdy && out_vld))
    else $error("ready and valid together");
  a_accept: assert property (@(posedge clk) disable iff (rst) in_fire |=> state == S_MUL0)
    else $error("accepted item not started");
  a_hold: assert property (@(posedge clk) disable iff (rst) out_vld && !out_rdy |=> out_vld)
    else $error("result dropped");
`endif

endmodule

// ===== hdl/fraction_alu_with_reduce_unit.sv =====
// multiply, divide, add, subtract pass states S_MUL0 and S_MUL1; reduce with
// a zero part goes from S_MUL0 straight to S_OUT; other reduce runs binary
// gcd steps plus 32 restoring division steps before the result.
// one item at a time, next accepted in the cycle after the result transfer.
// rst is synchronous, active high, and clears control.
// ----------------------------------------------------------------------------
// fraction_alu_with_reduce_unit
// fraction multiply, divide, add, subtract and gcd reduce
// ----------------------------------------------------------------------------
module fraction_alu_with_reduce_unit
  import fa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,  // req_type, a_num, a_den, b_num, b_den
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [135:0]  m_tdata   // res_num, res_den, overflow
);

  fa_cmd_t cmd;
  fa_sts_t sts;
  logic [MW-1:0] rn, rd;
  logic ro;

  // controller
  fa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready), .in_rdy(s_tready),
    .out_vld(m_tvalid), .out_rdy(m_tready), .cmd(cmd), .sts(sts)
  );

  // datapath
  fa_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_op(s_tdata[2:0]), .in_an(s_tdata[34:3]), .in_ad(s_tdata[66:35]),
    .in_bn(s_tdata[98:67]), .in_bd(s_tdata[130:99]),
    .res_num(rn), .res_den(rd), .res_ovf(ro)
  );

  assign m_tdata = {7'd0, ro, rd, rn};

endmodule
